// ----- src/mdio_clause22_read_master_core_macros.svh -----
// Assertion macros shared by the checker of the clause 22 read master.
// Needs nothing else; included by the checker file.
`ifndef MDIO_CLAUSE22_READ_MASTER_CORE_MACROS_SVH
`define MDIO_CLAUSE22_READ_MASTER_CORE_MACROS_SVH

`define MDC22_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MDC22_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mdc22_pkg.sv -----
// Types and constants of the clause 22 read master.
// Used by every module of the block; depends on nothing.
package mdc22_pkg;

    localparam int PREAMBLE_LENGTH_DEF = 32;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 16;
    localparam int HDR_BITS = 14;
    localparam int DATA_END = HDR_BITS + 17;
    localparam logic [1:0] ST_BITS = 2'b01;
    localparam logic [1:0] OP_READ = 2'b10;

    typedef struct packed {
        logic              start_req;
        logic [ADDR_W-1:0] phy_address;
        logic [ADDR_W-1:0] register_address;
        logic              mdio_in;
    } t_item;

    typedef struct packed {
        logic              mdio_out;
        logic              mdio_oe;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] read_data;
    } t_result;

endpackage

// ----- src/mdio_clause22_read_master_core.sv -----
// Top level of the MDIO clause 22 read frame master.
// Depends on mdc22_pkg, mdc22_in_stage, mdc22_frame_engine and mdc22_out_stage.
//
// Each input transfer is one MDC bit slot. A start request while idle latches
// the PHY and register addresses and opens a frame of PREAMBLE_LENGTH + 32
// slots: preamble, start, opcode, addresses, turnaround, 16 data bits sampled
// from mdio_in, and a final idle slot that carries done and the read word.
// Every input transfer yields exactly one output transfer with the level and
// drive enable for that slot. A start during a frame is ignored.
// A slot accepted by the block enters the input register, its decoded result is
// then loaded into the result register, and from there it is taken as an
// output transfer. The block takes one slot per cycle while the output does
// not stall. A stall on the output holds the result register; the input side
// stalls only once both registers are full. Reset returns the block to idle
// and empties both registers.
module mdio_clause22_read_master_core #(
    parameter int PREAMBLE_LENGTH = mdc22_pkg::PREAMBLE_LENGTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_start_req,
    input  logic [mdc22_pkg::ADDR_W-1:0] i_phy_address,
    input  logic [mdc22_pkg::ADDR_W-1:0] i_register_address,
    input  logic                         i_mdio_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_mdio_out,
    output logic                         o_mdio_oe,
    output logic                         o_busy_res,
    output logic                         o_done_res,
    output logic [mdc22_pkg::DATA_W-1:0] o_read_data
);

    mdc22_pkg::t_item   in_item;
    mdc22_pkg::t_item   stage_item;
    mdc22_pkg::t_result stage_result;
    mdc22_pkg::t_result out_result;
    logic               stage_valid;
    logic               in_load;
    logic               out_advance;

    assign in_item = '{start_req:        i_start_req,
                       phy_address:      i_phy_address,
                       register_address: i_register_address,
                       mdio_in:          i_mdio_in};

    assign o_stall = !in_load;

    mdc22_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (in_item),
        .i_advance (out_advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item),
        .o_load    (in_load)
    );

    mdc22_frame_engine #(
        .PREAMBLE_LENGTH (PREAMBLE_LENGTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (stage_valid && out_advance),
        .i_item   (stage_item),
        .o_result (stage_result)
    );

    mdc22_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stage_valid),
        .i_result  (stage_result),
        .i_stall   (i_stall),
        .o_advance (out_advance),
        .o_valid   (o_valid),
        .o_result  (out_result)
    );

    assign o_mdio_out  = out_result.mdio_out;
    assign o_mdio_oe   = out_result.mdio_oe;
    assign o_busy_res  = out_result.busy_res;
    assign o_done_res  = out_result.done_res;
    assign o_read_data = out_result.read_data;

endmodule

// ----- src/mdc22_in_stage.sv -----
// Input register of the clause 22 read master.
// Depends on mdc22_pkg for the item type.
module mdc22_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mdc22_pkg::t_item  i_item,
    input  logic              i_advance,
    output logic              o_valid,
    output mdc22_pkg::t_item  o_item,
    output logic              o_load
);

    logic             r_valid;
    mdc22_pkg::t_item r_item;

    assign o_load  = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- src/mdc22_frame_engine.sv -----
// Frame state and slot decode of the clause 22 read master.
// Depends on mdc22_pkg for types and frame layout constants.
module mdc22_frame_engine #(
    parameter int PREAMBLE_LENGTH = mdc22_pkg::PREAMBLE_LENGTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  mdc22_pkg::t_item   i_item,
    output mdc22_pkg::t_result o_result
);

    localparam int CntW = $clog2(PREAMBLE_LENGTH + 32);
    localparam int AddrBits = 2 * mdc22_pkg::ADDR_W;

    logic                          r_active;
    logic [CntW-1:0]               r_cnt;
    logic [AddrBits-1:0]           r_addr;
    logic [mdc22_pkg::DATA_W-1:0]  r_shift;

    logic                          n_active;
    logic [CntW-1:0]               n_cnt;
    logic [AddrBits-1:0]           n_addr;
    logic [mdc22_pkg::DATA_W-1:0]  n_shift;

    logic                          act;
    logic [CntW-1:0]               slot;
    logic [CntW-1:0]               k;
    logic [mdc22_pkg::HDR_BITS-1:0] hdr;
    logic [3:0]                    hdr_idx;
    logic                          done;

    always_comb begin
        act     = r_active || i_item.start_req;
        slot    = r_active ? r_cnt : '0;
        n_addr  = r_active ? r_addr : {i_item.phy_address, i_item.register_address};
        n_shift = r_active ? r_shift : '0;
        k       = slot - CntW'(PREAMBLE_LENGTH);
        hdr     = {mdc22_pkg::ST_BITS, mdc22_pkg::OP_READ, n_addr};
        hdr_idx = 4'(mdc22_pkg::HDR_BITS - 1) - k[3:0];
        done    = 1'b0;
        o_result = '0;
        if (act) begin
            o_result.busy_res = 1'b1;
            priority if (slot < CntW'(PREAMBLE_LENGTH)) begin
                o_result.mdio_out = 1'b1;
                o_result.mdio_oe  = 1'b1;
            end else if (k < CntW'(mdc22_pkg::HDR_BITS)) begin
                o_result.mdio_out = hdr[hdr_idx];
                o_result.mdio_oe  = 1'b1;
            end else if (k == CntW'(mdc22_pkg::HDR_BITS)) begin
                o_result.mdio_oe = 1'b0;
            end else if (k < CntW'(mdc22_pkg::DATA_END)) begin
                n_shift = {n_shift[mdc22_pkg::DATA_W-2:0], i_item.mdio_in};
            end else begin
                done               = 1'b1;
                o_result.done_res  = 1'b1;
                o_result.read_data = n_shift;
            end
        end
        n_active = act && !done;
        n_cnt    = (act && !done) ? slot + CntW'(1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (i_fire) begin
            r_active <= n_active;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_addr  <= n_addr;
            r_shift <= n_shift;
        end
    end

endmodule

// ----- src/mdc22_out_stage.sv -----
// Result register of the clause 22 read master.
// Depends on mdc22_pkg for the result type.
module mdc22_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  mdc22_pkg::t_result i_result,
    input  logic               i_stall,
    output logic               o_advance,
    output logic               o_valid,
    output mdc22_pkg::t_result o_result
);

    logic               r_valid;
    mdc22_pkg::t_result r_result;

    assign o_advance = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- src/mdc22_checker.sv -----
// Port-level assertions of the clause 22 read master and their binding.
// Depends on mdc22_pkg and the macro header.
`include "mdio_clause22_read_master_core_macros.svh"

module mdc22_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic                         o_mdio_out,
    input logic                         o_mdio_oe,
    input logic                         o_busy_res,
    input logic                         o_done_res,
    input logic [mdc22_pkg::DATA_W-1:0] o_read_data
);

    `MDC22_ASSERT_SAME(a_done_busy, i_clk, i_rst_n, o_valid && o_done_res, o_busy_res, "done outside a frame")
    `MDC22_ASSERT_SAME(a_release_low, i_clk, i_rst_n, o_valid && !o_mdio_oe, !o_mdio_out, "released slot drives a one")
    `MDC22_ASSERT_SAME(a_data_zero, i_clk, i_rst_n, o_valid && !o_done_res, o_read_data == '0, "read word shown before done")
    `MDC22_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_read_data) && $stable(o_done_res), "stalled transfer changed")

endmodule

bind mdio_clause22_read_master_core mdc22_checker u_mdc22_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_mdio_out  (o_mdio_out),
    .o_mdio_oe   (o_mdio_oe),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_read_data (o_read_data)
);

// ----- dv/tb_mdio_clause22_read_master_core.sv -----
// Self-checking testbench for the MDIO clause 22 read frame master.
// Uses mdc22_pkg and mdio_clause22_read_master_core; a slot-accurate predictor
// checks every output transfer against the frames and idle slots driven in.
`timescale 1ns / 100ps

module tb_mdio_clause22_read_master_core;

    localparam int PREAMBLE    = mdc22_pkg::PREAMBLE_LENGTH_DEF;
    localparam int FRAME_SLOTS = PREAMBLE + 32;
    localparam int DATA_FIRST  = PREAMBLE + mdc22_pkg::HDR_BITS + 1;
    localparam int HDR_BITS    = mdc22_pkg::HDR_BITS;
    localparam int DATA_END    = mdc22_pkg::DATA_END;
    localparam int ADDR_W      = mdc22_pkg::ADDR_W;
    localparam int DATA_W      = mdc22_pkg::DATA_W;
    localparam int IDLE_PCT    = 36;
    localparam int ITEM_TARGET = 450;
    localparam int DRAIN_AT    = 100;
    localparam int HOLD_START  = 150;
    localparam int HOLD_CYCLES = 50;
    localparam int CALM_FIRST  = 400;
    localparam int CALM_LAST   = 600;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                drv_valid   = 1'b0;
    logic                drv_start   = 1'b0;
    logic [ADDR_W-1:0]   drv_phy     = '0;
    logic [ADDR_W-1:0]   drv_regad   = '0;
    logic                drv_mdio_in = 1'b0;
    logic                rcv_stall   = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic                o_mdio_out;
    logic                o_mdio_oe;
    logic                o_busy_res;
    logic                o_done_res;
    logic [DATA_W-1:0]   o_read_data;

    mdc22_pkg::t_item   pending_slots[$];
    mdc22_pkg::t_result expected_slots[$];

    logic              fr_active = 1'b0;
    logic [6:0]        fr_slot   = '0;
    logic [9:0]        fr_addr   = '0;
    logic [DATA_W-1:0] fr_shift  = '0;

    int                 errors      = 0;
    int                 slots_sent  = 0;
    int                 frames_done = 0;
    int                 cycle_no    = 0;
    int                 hold_left   = 0;
    mdc22_pkg::t_item   acc_slot;
    mdc22_pkg::t_item   nxt_slot;
    mdc22_pkg::t_result want;

    mdio_clause22_read_master_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (drv_valid),
        .o_stall            (o_stall),
        .i_start_req        (drv_start),
        .i_phy_address      (drv_phy),
        .i_register_address (drv_regad),
        .i_mdio_in          (drv_mdio_in),
        .o_valid            (o_valid),
        .i_stall            (rcv_stall),
        .o_mdio_out         (o_mdio_out),
        .o_mdio_oe          (o_mdio_oe),
        .o_busy_res         (o_busy_res),
        .o_done_res         (o_done_res),
        .o_read_data        (o_read_data)
    );

    function automatic mdc22_pkg::t_result next_slot_result(mdc22_pkg::t_item it);
        mdc22_pkg::t_result  r;
        int                  k;
        logic [HDR_BITS-1:0] hdr;
        r = '0;
        if (!fr_active && it.start_req) begin
            fr_active = 1'b1;
            fr_slot   = '0;
            fr_addr   = {it.phy_address, it.register_address};
            fr_shift  = '0;
        end
        if (fr_active) begin
            r.busy_res = 1'b1;
            k = int'(fr_slot) - PREAMBLE;
            hdr = {mdc22_pkg::ST_BITS, mdc22_pkg::OP_READ, fr_addr};
            if (k < 0) begin
                r.mdio_out = 1'b1;
                r.mdio_oe  = 1'b1;
            end else if (k < HDR_BITS) begin
                r.mdio_out = hdr[HDR_BITS-1-k];
                r.mdio_oe  = 1'b1;
            end else if (k > HDR_BITS && k < DATA_END) begin
                fr_shift = {fr_shift[DATA_W-2:0], it.mdio_in};
            end else if (k >= DATA_END) begin
                r.done_res  = 1'b1;
                r.read_data = fr_shift;
            end
            if (r.done_res) begin
                fr_active = 1'b0;
                fr_slot   = '0;
            end else begin
                fr_slot = fr_slot + 7'd1;
            end
        end
        return r;
    endfunction

    task automatic add_idle(input logic st, input logic [4:0] phy, input logic [4:0] rad,
                            input logic din);
        mdc22_pkg::t_item it;
        it.start_req        = st;
        it.phy_address      = phy;
        it.register_address = rad;
        it.mdio_in          = din;
        pending_slots.push_back(it);
    endtask

    // A noisy frame carries stray start requests, one of them on the final slot.
    task automatic add_frame(input logic [4:0] phy, input logic [4:0] rad,
                             input logic [DATA_W-1:0] word, input bit noisy);
        mdc22_pkg::t_item it;
        int               s;
        int               d;
        for (s = 0; s < FRAME_SLOTS; s++) begin
            if (s == 0) begin
                it.start_req = 1'b1;
            end else if (noisy && s == FRAME_SLOTS - 1) begin
                it.start_req = 1'b1;
            end else begin
                it.start_req = noisy ? 1'($urandom_range(0, 1)) : 1'b0;
            end
            it.phy_address      = (s == 0) ? phy : 5'($urandom_range(0, 31));
            it.register_address = (s == 0) ? rad : 5'($urandom_range(0, 31));
            d = s - DATA_FIRST;
            if (d >= 0 && d < DATA_W) begin
                it.mdio_in = word[DATA_W-1-d];
            end else begin
                it.mdio_in = 1'($urandom_range(0, 1));
            end
            pending_slots.push_back(it);
        end
    endtask

    task automatic check_field(input string fname, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, exp_v, act_v);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_no <= cycle_no + 1;
        end
    end

    // Sender: one slot per transfer, held steady while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && !o_stall) begin
                acc_slot.start_req        = drv_start;
                acc_slot.phy_address      = drv_phy;
                acc_slot.register_address = drv_regad;
                acc_slot.mdio_in          = drv_mdio_in;
                expected_slots.push_back(next_slot_result(acc_slot));
                slots_sent++;
            end
            if (!drv_valid || !o_stall) begin
                if (pending_slots.size() != 0
                        && !(slots_sent == DRAIN_AT && expected_slots.size() != 0)
                        && ((cycle_no >= CALM_FIRST && cycle_no < CALM_LAST)
                            || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt_slot = pending_slots.pop_front();
                    drv_start   <= nxt_slot.start_req;
                    drv_phy     <= nxt_slot.phy_address;
                    drv_regad   <= nxt_slot.register_address;
                    drv_mdio_in <= nxt_slot.mdio_in;
                    drv_valid   <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a stretch without stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rcv_stall <= 1'b0;
            hold_left <= 0;
        end else if (cycle_no == HOLD_START) begin
            rcv_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            rcv_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (cycle_no >= CALM_FIRST && cycle_no < CALM_LAST) begin
            rcv_stall <= 1'b0;
        end else begin
            rcv_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !rcv_stall) begin
            if (expected_slots.size() == 0) begin
                errors++;
                $display("%0t: output transfer with no slot outstanding", $time);
            end else begin
                want = expected_slots.pop_front();
                check_field("mdio_out", 32'(want.mdio_out), 32'(o_mdio_out));
                check_field("mdio_oe", 32'(want.mdio_oe), 32'(o_mdio_oe));
                check_field("busy_res", 32'(want.busy_res), 32'(o_busy_res));
                check_field("done_res", 32'(want.done_res), 32'(o_done_res));
                check_field("read_data", 32'(want.read_data), 32'(o_read_data));
                if (want.done_res) begin
                    frames_done++;
                end
            end
        end
    end

    initial begin
        add_idle(1'b0, 5'd31, 5'd31, 1'b1);
        add_idle(1'b0, 5'd0, 5'd0, 1'b0);
        add_frame(5'd0, 5'd0, 16'hFFFF, 1'b0);
        add_frame(5'd31, 5'd31, 16'h0000, 1'b1);
        add_idle(1'b0, 5'd21, 5'd10, 1'b1);
        add_frame(5'b10101, 5'b01010, 16'hA5C3, 1'b0);
        while (pending_slots.size() < ITEM_TARGET) begin
            repeat ($urandom_range(0, 3)) begin
                add_idle(1'b0, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                         1'($urandom_range(0, 1)));
            end
            add_frame(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                      16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_slots.size() != 0 || drv_valid || expected_slots.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d MDC slots covering %0d read frames, with stray starts and idle slots,",
                 slots_sent, frames_done);
        $display("including a long output hold-off and a full drain of the pipeline.");
        if (errors == 0 && expected_slots.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
